// ===== hw/rtl/stfenc_pkg.sv =====
package stfenc_pkg;

	localparam logic [7:0] PREAMBLE_BYTE = 8'hFA;
	localparam logic [7:0] ESC_START = 8'h1E;
	localparam logic [7:0] ESC_STOP = 8'h1D;
	localparam logic [7:0] ESC_ESC = 8'h10;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] START_FLAG_RST = 8'hE1;
	localparam logic [7:0] STOP_FLAG_RST = 8'hE2;
	localparam logic [7:0] ESCAPE_BYTE_RST = 8'hEF;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_START_FLAG = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_FLAG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE = 2'd2;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] start_flag;
		logic [7:0] stop_flag;
		logic [7:0] escape_byte;
	} cfg_t;

	// one classified item: frame opens here, frame closes here, byte, crc after byte
	typedef struct packed {
		logic        hdr;
		logic        last;
		logic [7:0]  data;
		logic [15:0] crc;
	} desc_t;

	typedef struct packed {
		logic       esc;
		logic [7:0] code;
	} stuff_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// first match wins: start, stop, escape
	function automatic stuff_t stuff_map(input logic [7:0] b, input cfg_t cfg);
		stuff_t s;
		s.esc = 1'b1;
		s.code = ESC_ESC;
		if (b == cfg.start_flag) begin
			s.code = ESC_START;
		end else if (b == cfg.stop_flag) begin
			s.code = ESC_STOP;
		end else if (b == cfg.escape_byte) begin
			s.code = ESC_ESC;
		end else begin
			s.esc = 1'b0;
		end
		return s;
	endfunction

endpackage

// ===== hw/rtl/stfenc_front.sv =====
module stfenc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic                 q_full,
	output logic                 push,
	output stfenc_pkg::desc_t    push_desc
);

	logic [15:0] crc_q;
	logic        open_q;
	logic [15:0] crc_in;
	logic [15:0] crc_new;

	assign in_ready = !q_full;
	assign push = in_valid && in_ready;
	assign crc_in = open_q ? crc_q : stfenc_pkg::CRC_INIT;
	assign crc_new = stfenc_pkg::crc_update(crc_in, data_byte);

	always_comb begin
		push_desc.hdr = !open_q;
		push_desc.last = last_byte;
		push_desc.data = data_byte;
		push_desc.crc = crc_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= stfenc_pkg::CRC_INIT;
			open_q <= 1'b0;
		end else if (push) begin
			crc_q <= last_byte ? stfenc_pkg::CRC_INIT : crc_new;
			open_q <= !last_byte;
		end
	end

endmodule

// ===== hw/rtl/stfenc_fifo.sv =====
module stfenc_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  stfenc_pkg::desc_t    push_desc,
	input  logic                 pop,
	output logic                 full,
	output logic                 head_valid,
	output stfenc_pkg::desc_t    head_desc
);

	stfenc_pkg::desc_t               mem_q [stfenc_pkg::QDEPTH];
	logic [stfenc_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [stfenc_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [stfenc_pkg::QCNT_W-1:0]   cnt_q;

	assign full = (cnt_q == stfenc_pkg::QCNT_W'(stfenc_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == stfenc_pkg::QPTR_W'(stfenc_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == stfenc_pkg::QPTR_W'(stfenc_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/stfenc_back.sv =====
module stfenc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stfenc_pkg::cfg_t     cfg,
	input  logic                 head_valid,
	input  stfenc_pkg::desc_t    head_desc,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 run_last,
	output logic                 frame_end
);

	typedef enum logic [6:0] {
		PH_NEW   = 7'b0000001,
		PH_PRE   = 7'b0000010,
		PH_START = 7'b0000100,
		PH_DATA  = 7'b0001000,
		PH_CRCH  = 7'b0010000,
		PH_CRCL  = 7'b0100000,
		PH_STOP  = 7'b1000000
	} phase_t;

	phase_t ph_q;
	phase_t cur_ph;
	phase_t ph_nxt;
	logic   esc_q;
	logic   esc_nxt;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 run_last_q;
	logic                 frame_end_q;

	logic                 adv;
	logic [7:0]           sel_byte;
	stfenc_pkg::stuff_t   st;
	logic [7:0]           byte_nxt;
	logic                 final_nxt;
	logic                 end_nxt;

	assign adv = head_valid && (!out_valid_q || out_ready);
	assign pop = adv && final_nxt;

	always_comb begin
		if (ph_q == PH_NEW) begin
			cur_ph = head_desc.hdr ? PH_PRE : PH_DATA;
		end else begin
			cur_ph = ph_q;
		end
	end

	always_comb begin
		unique case (cur_ph)
			PH_CRCH: sel_byte = head_desc.crc[15:8];
			PH_CRCL: sel_byte = head_desc.crc[7:0];
			default: sel_byte = head_desc.data;
		endcase
	end

	assign st = stfenc_pkg::stuff_map(sel_byte, cfg);

	always_comb begin
		byte_nxt = sel_byte;
		final_nxt = 1'b0;
		end_nxt = 1'b0;
		ph_nxt = cur_ph;
		esc_nxt = 1'b0;
		unique case (cur_ph)
			PH_PRE: begin
				byte_nxt = stfenc_pkg::PREAMBLE_BYTE;
				ph_nxt = PH_START;
			end
			PH_START: begin
				byte_nxt = cfg.start_flag;
				ph_nxt = PH_DATA;
			end
			PH_DATA, PH_CRCH, PH_CRCL: begin
				if (esc_q) begin
					byte_nxt = st.code;
				end else if (st.esc) begin
					byte_nxt = cfg.escape_byte;
				end else begin
					byte_nxt = sel_byte;
				end
				if (!esc_q && st.esc) begin
					esc_nxt = 1'b1;
					ph_nxt = cur_ph;
				end else begin
					unique case (cur_ph)
						PH_DATA: begin
							if (head_desc.last) begin
								ph_nxt = PH_CRCH;
							end else begin
								final_nxt = 1'b1;
								ph_nxt = PH_NEW;
							end
						end
						PH_CRCH: ph_nxt = PH_CRCL;
						default: ph_nxt = PH_STOP;
					endcase
				end
			end
			PH_STOP: begin
				byte_nxt = cfg.stop_flag;
				final_nxt = 1'b1;
				end_nxt = 1'b1;
				ph_nxt = PH_NEW;
			end
			default: begin
				ph_nxt = PH_NEW;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_NEW;
			esc_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				ph_q <= ph_nxt;
				esc_q <= esc_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= byte_nxt;
			run_last_q <= final_nxt;
			frame_end_q <= end_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign run_last = run_last_q;
	assign frame_end = frame_end_q;

endmodule

// ===== hw/rtl/stuffed_frame_encoder_crc16_core.sv =====
// channel | dir | handshake           | payload
// in      | in  | in_valid, in_ready   | data_byte[7:0], last_byte
// out     | out | out_valid, out_ready | out_byte[7:0], run_last, frame_end
// cfg     | in  | cfg_we               | cfg_index[1:0], cfg_data[7:0]
//
// An accepted item is classified (CRC, frame open) in the cycle it enters and
// queued; out_valid rises once the back end loads the registered output from
// the queue head, which waits while a held output byte is not taken.
// The back end sends one line byte per cycle while the queue holds an item
// and the output is not stalled; an item causes 1 to 9 line bytes, 1-2 per
// payload byte mid-frame. A two-entry queue lets input and output stall
// independently; in_ready drops while the queue holds two items.
// Reset clears frame state, queue, output valid and restores flag defaults.
module stuffed_frame_encoder_crc16_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          data_byte,
	input  logic                                last_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          out_byte,
	output logic                                run_last,
	output logic                                frame_end,
	input  logic                                cfg_we,
	input  logic [stfenc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                          cfg_data
);

	stfenc_pkg::cfg_t  cfg_q;
	logic              q_full;
	logic              push;
	stfenc_pkg::desc_t push_desc;
	logic              pop;
	logic              head_valid;
	stfenc_pkg::desc_t head_desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_flag <= stfenc_pkg::START_FLAG_RST;
			cfg_q.stop_flag <= stfenc_pkg::STOP_FLAG_RST;
			cfg_q.escape_byte <= stfenc_pkg::ESCAPE_BYTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				stfenc_pkg::REG_START_FLAG: cfg_q.start_flag <= cfg_data;
				stfenc_pkg::REG_STOP_FLAG: cfg_q.stop_flag <= cfg_data;
				stfenc_pkg::REG_ESCAPE_BYTE: cfg_q.escape_byte <= cfg_data;
				default: ;
			endcase
		end
	end

	stfenc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	stfenc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	stfenc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_end  (frame_end)
	);

endmodule

// ===== sim/stuffed_frame_encoder_crc16_core_test.sv =====
module stuffed_frame_encoder_crc16_core_test;

	localparam logic [stfenc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int LONG_HOLD = 300;
	localparam int IDLE_LIMIT = 5000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} payload_t;

	typedef struct packed {
		logic [7:0] value;
		logic       run_last;
		logic       frame_end;
	} line_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;
	logic run_last;
	logic frame_end;
	logic cfg_we = 1'b0;
	logic [stfenc_pkg::CFG_IDX_W-1:0] cfg_index = stfenc_pkg::REG_START_FLAG;
	logic [7:0] cfg_data = 8'h00;

	payload_t payload_queue[$];
	line_t line_bytes_due[$];

	logic [7:0] enc_start = stfenc_pkg::START_FLAG_RST;
	logic [7:0] enc_stop = stfenc_pkg::STOP_FLAG_RST;
	logic [7:0] enc_escape = stfenc_pkg::ESCAPE_BYTE_RST;
	logic [15:0] crc_run = stfenc_pkg::CRC_INIT;
	logic frame_active = 1'b0;

	logic in_taken = 1'b0;
	logic steady = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int long_holds_asked = 0;
	int long_holds_done = 0;
	int idle_cycles = 0;
	int mismatches = 0;
	int offered = 0;
	int accepted = 0;

	stuffed_frame_encoder_crc16_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.frame_end (frame_end),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic queue_line(input logic [7:0] b, input logic fe);
		line_bytes_due.insert(line_bytes_due.size(),
			line_t'{value: b, run_last: 1'b0, frame_end: fe});
	endtask

	task automatic queue_stuffed(input logic [7:0] b);
		if (b == enc_start) begin
			queue_line(enc_escape, 1'b0);
			queue_line(stfenc_pkg::ESC_START, 1'b0);
		end else if (b == enc_stop) begin
			queue_line(enc_escape, 1'b0);
			queue_line(stfenc_pkg::ESC_STOP, 1'b0);
		end else if (b == enc_escape) begin
			queue_line(enc_escape, 1'b0);
			queue_line(stfenc_pkg::ESC_ESC, 1'b0);
		end else begin
			queue_line(b, 1'b0);
		end
	endtask

	task automatic encode_payload(input payload_t p);
		logic [15:0] c;
		if (!frame_active) begin
			crc_run = stfenc_pkg::CRC_INIT;
			queue_line(stfenc_pkg::PREAMBLE_BYTE, 1'b0);
			queue_line(enc_start, 1'b0);
		end
		c = crc_run ^ {p.data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ stfenc_pkg::CRC_POLY) : {c[14:0], 1'b0};
		end
		crc_run = c;
		queue_stuffed(p.data);
		if (p.last) begin
			queue_stuffed(crc_run[15:8]);
			queue_stuffed(crc_run[7:0]);
			queue_line(enc_stop, 1'b1);
			crc_run = stfenc_pkg::CRC_INIT;
			frame_active = 1'b0;
		end else begin
			frame_active = 1'b1;
		end
		line_bytes_due[line_bytes_due.size()-1].run_last = 1'b1;
	endtask

	// accepted input items feed the predictor; output items are checked in order
	always @(posedge clk) begin
		line_t exp_line;
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			accepted++;
			encode_payload('{data: data_byte, last: last_byte});
		end
		if (out_valid && out_ready) begin
			if (line_bytes_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected item: expected none, %s %02h %0b %0b",
					$time, "actual byte/run_last/frame_end", out_byte, run_last,
					frame_end);
			end else begin
				exp_line = line_bytes_due.pop_front();
				if (out_byte !== exp_line.value) begin
					mismatches++;
					$display("%0t: out_byte mismatch: expected %02h, actual %02h",
						$time, exp_line.value, out_byte);
				end
				if (run_last !== exp_line.run_last) begin
					mismatches++;
					$display("%0t: run_last mismatch: expected %0b, actual %0b",
						$time, exp_line.run_last, run_last);
				end
				if (frame_end !== exp_line.frame_end) begin
					mismatches++;
					$display("%0t: frame_end mismatch: expected %0b, actual %0b",
						$time, exp_line.frame_end, frame_end);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("stuffed_frame_encoder_crc16_core regression: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		payload_t p;
		if (in_valid && !in_taken) begin
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (payload_queue.size() > 0 && !steady && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			gap_left <= $urandom_range(0, 14);
		end else if (payload_queue.size() > 0) begin
			p = payload_queue.pop_front();
			in_valid <= 1'b1;
			data_byte <= p.data;
			last_byte <= p.last;
		end else begin
			in_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (long_holds_done != long_holds_asked) begin
			out_ready <= 1'b0;
			stall_left <= LONG_HOLD;
			long_holds_done <= long_holds_done + 1;
		end else if (!steady && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 14);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic offer(input logic [7:0] d, input logic l);
		offered++;
		payload_queue.insert(payload_queue.size(), payload_t'{data: d, last: l});
	endtask

	task automatic drain();
		while (accepted != offered || line_bytes_due.size() > 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [stfenc_pkg::CFG_IDX_W-1:0] idx,
		input logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			stfenc_pkg::REG_START_FLAG: enc_start = v;
			stfenc_pkg::REG_STOP_FLAG: enc_stop = v;
			stfenc_pkg::REG_ESCAPE_BYTE: enc_escape = v;
			default: ;
		endcase
	endtask

	task automatic set_flags(input logic [7:0] s, input logic [7:0] t, input logic [7:0] e);
		write_reg(stfenc_pkg::REG_START_FLAG, s);
		write_reg(stfenc_pkg::REG_STOP_FLAG, t);
		write_reg(stfenc_pkg::REG_ESCAPE_BYTE, e);
	endtask

	// mostly short frames; three in sixteen bytes collide with a flag value
	task automatic random_phase(input int n);
		logic [7:0] d;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 15))
				0: d = enc_start;
				1: d = enc_stop;
				2: d = enc_escape;
				3: d = stfenc_pkg::PREAMBLE_BYTE;
				default: d = 8'($urandom_range(0, 255));
			endcase
			offer(d, $urandom_range(0, 4) == 0);
		end
		drain();
	endtask

	initial begin
		logic [7:0] v;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		offer(8'h00, 1'b1);
		offer(8'hFF, 1'b1);
		offer(stfenc_pkg::START_FLAG_RST, 1'b1);
		offer(stfenc_pkg::STOP_FLAG_RST, 1'b1);
		offer(stfenc_pkg::ESCAPE_BYTE_RST, 1'b1);
		offer(stfenc_pkg::PREAMBLE_BYTE, 1'b0);
		offer(stfenc_pkg::START_FLAG_RST, 1'b0);
		offer(stfenc_pkg::STOP_FLAG_RST, 1'b0);
		offer(stfenc_pkg::ESCAPE_BYTE_RST, 1'b0);
		offer(8'h5A, 1'b1);
		drain();

		// flag change inside an open frame
		offer(8'h41, 1'b0);
		drain();
		write_reg(stfenc_pkg::REG_START_FLAG, 8'h41);
		offer(8'h41, 1'b1);
		drain();

		write_reg(REG_SPARE, 8'h00);
		offer(8'h00, 1'b1);
		drain();

		set_flags(8'h7E, 8'h7E, 8'h7E);
		offer(8'h7E, 1'b0);
		offer(8'h7E, 1'b1);
		drain();

		set_flags(8'h00, 8'h33, 8'h33);
		offer(8'h33, 1'b0);
		offer(8'h00, 1'b1);
		drain();

		set_flags(8'hFF, 8'h00, 8'hFF);
		offer(8'hFF, 1'b0);
		offer(8'h00, 1'b0);
		offer(8'h80, 1'b1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_flags(stfenc_pkg::START_FLAG_RST, stfenc_pkg::STOP_FLAG_RST,
					stfenc_pkg::ESCAPE_BYTE_RST);
				1: set_flags(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				2: begin
					v = 8'($urandom_range(0, 255));
					set_flags(v, v, v);
				end
				3: set_flags(8'h00, 8'hFF, 8'($urandom_range(1, 254)));
				4: set_flags(8'hFF, 8'h00, 8'h00);
				default: set_flags(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			endcase
			if ($urandom_range(0, 1) == 0) begin
				write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
			end
			if (ph == 1) begin
				long_holds_asked++;
			end
			if (ph == 5) begin
				steady = 1'b1;
			end
			random_phase(60);
		end

		drain();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && line_bytes_due.size() == 0) begin
			$display("stuffed_frame_encoder_crc16_core regression: pass");
		end else begin
			$display("stuffed_frame_encoder_crc16_core regression: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/stfenc_pkg.sv
hw/rtl/stfenc_front.sv
hw/rtl/stfenc_fifo.sv
hw/rtl/stfenc_back.sv
hw/rtl/stuffed_frame_encoder_crc16_core.sv
sim/stuffed_frame_encoder_crc16_core_test.sv
